FILE: rtl/core/hkn_pkg.sv
// shared types, widths and helpers of the hamming k-nearest keeper
// no dependencies; used by hkn_dist and the top level
`default_nettype none

package hkn_pkg;

    localparam int DIST_W  = 7;
    localparam int OUT_W   = 8;
    localparam int LABEL_W = 16;
    localparam int ENTRY_W = DIST_W + OUT_W + LABEL_W;

    // register values after reset
    localparam logic [3:0]        TOP_COUNT_RESET    = 4'd1;
    localparam logic [DIST_W-1:0] PATTERN_BITS_RESET = 7'd64;

    // one neighbor slot as it sits in the slot ram
    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [OUT_W-1:0]   output_value;
        logic [LABEL_W-1:0] label;
    } slot_entry_t;

    // distance unit status
    typedef struct packed {
        logic              busy;
        logic [DIST_W-1:0] distance;
    } dist_status_t;

    function automatic logic [3:0] popcount8(input logic [7:0] value);
        logic [3:0] sum;
        sum = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + {3'd0, value[i]};
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hkn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module hkn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hkn_dist.sv
// iterative hamming distance unit: one byte of the masked xor per cycle
// depends on hkn_pkg (popcount8, dist_status_t)
`default_nettype none

module hkn_dist #(
    parameter int PATTERN_WIDTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [PATTERN_WIDTH-1:0]   a,
    input  wire logic [PATTERN_WIDTH-1:0]   b,
    input  wire logic [hkn_pkg::DIST_W-1:0] bits,
    output hkn_pkg::dist_status_t           status
);

    localparam int STEPS  = (PATTERN_WIDTH + 7) / 8;
    localparam int XW     = STEPS * 8;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [PATTERN_WIDTH-1:0]   mask;
    logic [XW-1:0]              x_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [hkn_pkg::DIST_W-1:0] acc_reg;
    logic                       busy_reg;

    // bits at or above the active count drop out
    always_comb
    begin
        for (int i = 0; i < PATTERN_WIDTH; i++)
        begin
            mask[i] = (7'(i) < bits);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(STEPS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= XW'((a ^ b) & mask);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_reg >> 8;
            acc_reg <= acc_reg + 7'(hkn_pkg::popcount8(x_reg[7:0]));
        end
    end

    assign status.busy     = busy_reg;
    assign status.distance = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hamming_top_k_neighbour_keeper_unit.sv
// top level of the hamming k-nearest neighbor keeper for one vg-ram neuron
// depends on hkn_pkg, hkn_dist (distance unit) and hkn_ram (slot store)
`default_nettype none

// channel   direction  handshake                     payload
// item      in         item_valid / item_ready       first, query_bits, stored_bits,
//                                                    stored_output, pattern_index, last
// result    out        result_valid / result_ready   slot, output_value, distance,
//                                                    label_index, last_result
// config    in         apb psel / penable / pready   top_count @0x0, pattern_bits @0x4
//
// one item runs through the distance unit (one byte popcount per cycle), then through the
// slot scan (one ram read per cycle, one compare behind it) and the update state. a last
// item then reports n beats; each passes the states rep_rd and rep_ld, then rep_wait holds
// the beat until result_ready takes it.
// reset: slots read as cleared through the valid bits, no clearing pass is needed.
// item_ready is low from acceptance until the item and its report are finished.

module hamming_top_k_neighbour_keeper_unit #(
    parameter int TOP_MAX       = 8,
    parameter int PATTERN_WIDTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // item channel
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic                        first,
    input  wire logic [PATTERN_WIDTH-1:0]    query_bits,
    input  wire logic [PATTERN_WIDTH-1:0]    stored_bits,
    input  wire logic [7:0]                  stored_output,
    input  wire logic [15:0]                 pattern_index,
    input  wire logic                        last,

    // result channel
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [2:0]                       slot,
    output logic [7:0]                       output_value,
    output logic [6:0]                       distance,
    output logic [15:0]                      label_index,
    output logic                             last_result,

    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    localparam int IDX_W = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
    localparam int CNT_W = $clog2(TOP_MAX + 1);
    localparam int DW    = hkn_pkg::DIST_W;

    // distance that slots hold after reset
    localparam logic [DW-1:0] CLEAR_DIST_RESET =
        (hkn_pkg::PATTERN_BITS_RESET > DW'(PATTERN_WIDTH)) ?
        DW'(PATTERN_WIDTH) : hkn_pkg::PATTERN_BITS_RESET;

    // register index decoded from paddr[2]
    localparam logic REG_TOP_COUNT    = 1'b0;
    localparam logic REG_PATTERN_BITS = 1'b1;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_COUNT    = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_UPDATE   = 3'd3;
    localparam logic [2:0] S_REP_RD   = 3'd4;
    localparam logic [2:0] S_REP_LD   = 3'd5;
    localparam logic [2:0] S_REP_WAIT = 3'd6;

    // configuration registers
    logic [3:0]    top_count_reg;
    logic [DW-1:0] pattern_bits_reg;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [TOP_MAX-1:0] valid_reg, valid_next;
    logic [DW-1:0]      clear_dist_reg, clear_dist_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               issuing_reg, issuing_next;
    logic               cmp_pending_reg, cmp_pending_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [DW-1:0]      best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]   rep_idx_reg, rep_idx_next;
    logic               rd_valid_reg;
    logic               result_valid_reg, result_valid_next;

    // item payload held for the run
    logic                        item_last_reg;
    logic [hkn_pkg::OUT_W-1:0]   item_output_reg;
    logic [hkn_pkg::LABEL_W-1:0] item_label_reg;

    // result payload
    logic [2:0]                  slot_reg;
    logic [7:0]                  output_value_reg;
    logic [DW-1:0]               distance_reg;
    logic [15:0]                 label_index_reg;
    logic                        last_result_reg;

    logic                  item_take;
    logic                  cfg_write;
    logic [DW-1:0]         bits_act;
    logic [CNT_W-1:0]      n_act;
    logic [CNT_W-1:0]      n_last;
    hkn_pkg::dist_status_t dist_status;

    logic [IDX_W-1:0]           ram_raddr;
    logic [hkn_pkg::ENTRY_W-1:0] ram_rdata;
    logic                        ram_we;
    hkn_pkg::slot_entry_t        ram_wentry;
    hkn_pkg::slot_entry_t        ram_entry;
    hkn_pkg::slot_entry_t        slot_entry;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg    <= hkn_pkg::TOP_COUNT_RESET;
            pattern_bits_reg <= hkn_pkg::PATTERN_BITS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_TOP_COUNT:    top_count_reg    <= pwdata[3:0];
                REG_PATTERN_BITS: pattern_bits_reg <= pwdata[DW-1:0];
                default:          top_count_reg    <= top_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TOP_COUNT:    prdata = {28'd0, top_count_reg};
            REG_PATTERN_BITS: prdata = {25'd0, pattern_bits_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // saturated views of the registers
    assign bits_act = (pattern_bits_reg > DW'(PATTERN_WIDTH)) ?
                      DW'(PATTERN_WIDTH) : pattern_bits_reg;

    always_comb
    begin
        if (top_count_reg == 4'd0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(top_count_reg) > TOP_MAX)
        begin
            n_act = CNT_W'(TOP_MAX);
        end
        else
        begin
            n_act = CNT_W'(top_count_reg);
        end
    end

    assign n_last = n_act - CNT_W'(1);

    // ---------------------------------------------------------------
    // distance unit, started at item acceptance
    // ---------------------------------------------------------------
    assign item_ready = (state_reg == S_IDLE);
    assign item_take  = item_valid && item_ready;

    hkn_dist #(
        .PATTERN_WIDTH(PATTERN_WIDTH)
    ) u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (item_take),
        .a      (query_bits),
        .b      (stored_bits),
        .bits   (bits_act),
        .status (dist_status)
    );

    // ---------------------------------------------------------------
    // slot store; a slot without its valid bit reads as cleared
    // ---------------------------------------------------------------
    assign ram_raddr = (state_reg == S_SCAN) ? scan_idx_reg : rep_idx_reg;
    assign ram_we    = (state_reg == S_UPDATE) &&
                       (dist_status.distance < best_dist_reg);

    assign ram_wentry.distance     = dist_status.distance;
    assign ram_wentry.output_value = item_output_reg;
    assign ram_wentry.label        = item_label_reg;

    hkn_ram #(
        .WIDTH(hkn_pkg::ENTRY_W),
        .DEPTH(TOP_MAX)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_idx_reg),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_entry = ram_rdata;

    always_comb
    begin
        if (rd_valid_reg)
        begin
            slot_entry = ram_entry;
        end
        else
        begin
            slot_entry.distance     = clear_dist_reg;
            slot_entry.output_value = '0;
            slot_entry.label        = '0;
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        clear_dist_next   = clear_dist_reg;
        scan_idx_next     = scan_idx_reg;
        issuing_next      = issuing_reg;
        cmp_pending_next  = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        best_idx_next     = best_idx_reg;
        best_dist_next    = best_dist_reg;
        rep_idx_next      = rep_idx_reg;
        result_valid_next = result_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    // first flag: every slot back to the cleared value
                    if (first)
                    begin
                        valid_next      = '0;
                        clear_dist_next = bits_act;
                    end
                    state_next = S_COUNT;
                end
            end

            S_COUNT:
            begin
                if (!dist_status.busy)
                begin
                    scan_idx_next = '0;
                    issuing_next  = 1'b1;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read side: one slot address per cycle
                if (issuing_reg)
                begin
                    cmp_pending_next = 1'b1;
                    cmp_idx_next     = scan_idx_reg;
                    if (CNT_W'(scan_idx_reg) == n_last)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                // compare side: first slot with the largest distance wins
                if (cmp_pending_reg)
                begin
                    if ((cmp_idx_reg == '0) || (best_dist_reg < slot_entry.distance))
                    begin
                        best_idx_next  = cmp_idx_reg;
                        best_dist_next = slot_entry.distance;
                    end
                    if (CNT_W'(cmp_idx_reg) == n_last)
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end

            S_UPDATE:
            begin
                if (ram_we)
                begin
                    valid_next[best_idx_reg] = 1'b1;
                end
                rep_idx_next = '0;
                state_next   = item_last_reg ? S_REP_RD : S_IDLE;
            end

            S_REP_RD:
            begin
                state_next = S_REP_LD;
            end

            S_REP_LD:
            begin
                result_valid_next = 1'b1;
                state_next        = S_REP_WAIT;
            end

            S_REP_WAIT:
            begin
                if (result_ready)
                begin
                    result_valid_next = 1'b0;
                    if (last_result_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rep_idx_next = rep_idx_reg + IDX_W'(1);
                        state_next   = S_REP_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            clear_dist_reg   <= CLEAR_DIST_RESET;
            scan_idx_reg     <= '0;
            issuing_reg      <= 1'b0;
            cmp_pending_reg  <= 1'b0;
            cmp_idx_reg      <= '0;
            best_idx_reg     <= '0;
            best_dist_reg    <= '0;
            rep_idx_reg      <= '0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            clear_dist_reg   <= clear_dist_next;
            scan_idx_reg     <= scan_idx_next;
            issuing_reg      <= issuing_next;
            cmp_pending_reg  <= cmp_pending_next;
            cmp_idx_reg      <= cmp_idx_next;
            best_idx_reg     <= best_idx_next;
            best_dist_reg    <= best_dist_next;
            rep_idx_reg      <= rep_idx_next;
            // valid bit travels with the registered ram read
            rd_valid_reg     <= valid_reg[ram_raddr];
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_last_reg   <= last;
            item_output_reg <= stored_output;
            item_label_reg  <= pattern_index;
        end
        if (state_reg == S_REP_LD)
        begin
            slot_reg         <= 3'(rep_idx_reg);
            output_value_reg <= slot_entry.output_value;
            distance_reg     <= slot_entry.distance;
            label_index_reg  <= slot_entry.label;
            last_result_reg  <= (CNT_W'(rep_idx_reg) == n_last);
        end
    end

    assign result_valid = result_valid_reg;
    assign slot         = slot_reg;
    assign output_value = output_value_reg;
    assign distance     = distance_reg;
    assign label_index  = label_index_reg;
    assign last_result  = last_result_reg;

endmodule

`default_nettype wire
